// ===== rtl/core/rst_pkg.sv =====
// ----------------------------------------------------------------------------
// rst_pkg: shared types and constants of the rectilinear spanning tree
// Widths of edge fields, sort keys and the per-cell edge record.
// ----------------------------------------------------------------------------
package rst_pkg;

	localparam int MAX_EDGES    = 64;
	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;

	localparam int EIDX_W = $clog2(MAX_EDGES);
	localparam int CNT_W  = $clog2(MAX_EDGES + 1);
	localparam int VIDX_W = 6;
	localparam int PAR_W  = $clog2(MAX_VERTICES);
	localparam int MAN_W  = COORD_BITS + 1;
	localparam int EUC_W  = 2 * COORD_BITS + 1;
	localparam int KEY_W  = MAN_W + EUC_W + EIDX_W;

	// one edge as it sits in a sort cell
	typedef struct packed {
		logic [KEY_W-1:0]  key;   // manhattan, squared length, input position
		logic [VIDX_W-1:0] va;
		logic [VIDX_W-1:0] vb;
	} edge_rec_t;

endpackage

// ===== rtl/core/rectilinear_spanning_tree.sv =====
// ----------------------------------------------------------------------------
// rectilinear_spanning_tree: Kruskal spanning tree over a candidate edge list
//
// Input channel (valid/ready) takes edge beats only while loading: in_ready
// drops for the cycle in which a stored beat's distances are registered, so
// a new beat is not taken before the last has entered the chain. Each edge
// enters a chain of MAX_EDGES sort cells; every cycle a record moves one cell
// further, so the list ends up ordered by manhattan length, squared length,
// input position. The beat with last_edge closes the list: once it is
// registered the chain is flushed, then drained head first into a union-find
// engine with a registered parent table. Per drained edge: a self loop is
// passed over in the pick state, else each end's root is found through the
// read and check states with path-halving steps, then the link state; the
// larger root is linked under the smaller one. Finally one result beat per
// edge, in input order, one per cycle while the receiver is ready, goes out
// through an output register; a stalled receiver just holds that register
// and the input stays blocked until the run ends.
// Reset clears the chain, edge count, parent table and all control state.
// Edges beyond MAX_EDGES are dropped; last_edge still starts the run.
// ----------------------------------------------------------------------------
module rectilinear_spanning_tree (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  vertex_a,
	input  logic [5:0]  vertex_b,
	input  logic [15:0] endpoint_a_x,
	input  logic [15:0] endpoint_a_y,
	input  logic [15:0] endpoint_b_x,
	input  logic [15:0] endpoint_b_y,
	input  logic        last_edge,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  edge_index,
	output logic        in_tree,
	output logic        last_result
);
	localparam int NE = rst_pkg::MAX_EDGES;
	localparam int NV = rst_pkg::MAX_VERTICES;
	localparam int EW = rst_pkg::EIDX_W;
	localparam int CW = rst_pkg::CNT_W;
	localparam int PW = rst_pkg::PAR_W;
	localparam int CB = rst_pkg::COORD_BITS;
	localparam int MW = rst_pkg::MAN_W;
	localparam int UW = rst_pkg::EUC_W;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_FLUSH = 4'd1;
	localparam logic [3:0] ST_PICK  = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_CHK   = 4'd4;
	localparam logic [3:0] ST_HALF  = 4'd5;
	localparam logic [3:0] ST_LINK  = 4'd6;
	localparam logic [3:0] ST_EMIT  = 4'd7;
	localparam logic [3:0] ST_CLR   = 4'd8;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] step_q;
	logic          flag_q [NE];
	logic [PW-1:0] x_q, ra_q;
	logic          side_q;
	logic [EW-1:0] cur_e_q;
	logic [rst_pkg::VIDX_W-1:0] cur_vb_q;
	logic          ovld_q;
	logic [5:0]    oidx_q;
	logic          otree_q, olast_q;

	// ---- front end: distances, pipelined into the chain
	logic [CB-1:0] ax, ay, bx, by, dx, dy;
	logic [MW-1:0] man;
	logic [2*CB-1:0] dx2_s1, dy2_s1;
	logic [MW-1:0] man_s1;
	logic [5:0]    va_s1, vb_s1;
	logic [EW-1:0] pos_s1;
	logic          vld_s1, last_s1;
	logic          acc;

	assign ax = endpoint_a_x[CB-1:0];
	assign ay = endpoint_a_y[CB-1:0];
	assign bx = endpoint_b_x[CB-1:0];
	assign by = endpoint_b_y[CB-1:0];
	assign dx = (ax >= bx) ? ax - bx : bx - ax;
	assign dy = (ay >= by) ? ay - by : by - ay;
	assign man = {1'b0, dx} + {1'b0, dy};

	assign in_ready = (state_q == ST_LOAD) && !vld_s1;
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= acc && (cnt_q < CW'(NE));
			last_s1 <= acc && last_edge;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dx2_s1 <= dx * dx;
			dy2_s1 <= dy * dy;
			man_s1 <= man;
			va_s1  <= vertex_a;
			vb_s1  <= vertex_b;
			pos_s1 <= cnt_q[EW-1:0];
		end
	end

	// ---- chain of sort cells
	rst_pkg::edge_rec_t new_rec;
	logic               pass_vld [NE];
	rst_pkg::edge_rec_t pass_rec [NE];
	logic               held_vld [NE];
	rst_pkg::edge_rec_t held_rec [NE];
	logic               ins, shift, clr_chain;

	assign new_rec.key = {man_s1, UW'({1'b0, dx2_s1} + {1'b0, dy2_s1}), pos_s1};
	assign new_rec.va  = va_s1;
	assign new_rec.vb  = vb_s1;

	assign ins       = (state_q == ST_LOAD) || (state_q == ST_FLUSH);
	assign shift     = (state_q == ST_PICK);
	assign clr_chain = (state_q == ST_CLR);

	// insert flows toward the tail; on drain records move toward the head
	genvar g;
	generate
		for (g = 0; g < NE; g++) begin : g_cell
			logic               ci_vld, nx_vld;
			rst_pkg::edge_rec_t ci_rec, nx_rec;
			if (g == 0) begin : g_first
				assign ci_vld = vld_s1;
				assign ci_rec = new_rec;
			end else begin : g_inner
				assign ci_vld = pass_vld[g-1];
				assign ci_rec = pass_rec[g-1];
			end
			if (g == NE - 1) begin : g_last
				assign nx_vld = 1'b0;
				assign nx_rec = '0;
			end else begin : g_body
				assign nx_vld = held_vld[g+1];
				assign nx_rec = held_rec[g+1];
			end
			rst_sort_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clear    (clr_chain),
				.ins      (ins),
				.shift    (shift),
				.in_vld   (ci_vld),
				.in_rec   (ci_rec),
				.nxt_vld  (nx_vld),
				.nxt_rec  (nx_rec),
				.pass_vld (pass_vld[g]),
				.pass_rec (pass_rec[g]),
				.held_vld (held_vld[g]),
				.held_rec (held_rec[g])
			);
		end
	endgenerate

	// head of chain (held record of cell 0) during drain
	rst_pkg::edge_rec_t head_rec;
	assign head_rec = held_rec[0];

	// ---- union-find: parent table with registered read, set bits for identity
	logic [PW-1:0] par_mem [NV];
	logic [NV-1:0] par_set_q;
	logic [PW-1:0] rd_addr, rd_addr_q, rd_data_q, rd_val;
	logic          rd_set_q;
	logic          par_we;
	logic [PW-1:0] par_wa, par_wd;
	logic          flag_we, flag_wd;
	logic [EW-1:0] flag_wa;
	logic          va_ok, vb_ok;

	assign va_ok = 32'(head_rec.va) < NV;
	assign vb_ok = 32'(head_rec.vb) < NV;

	// parent of the last address read; an unwritten entry is its own root
	assign rd_val  = rd_set_q ? rd_data_q : rd_addr_q;
	assign rd_addr = ((state_q == ST_CHK) || (state_q == ST_HALF)) ? rd_val : x_q;

	assign par_we = (state_q == ST_HALF) || ((state_q == ST_LINK) && (ra_q != x_q));
	assign par_wa = (state_q == ST_HALF) ? x_q : ((ra_q < x_q) ? x_q : ra_q);
	assign par_wd = (state_q == ST_HALF) ? rd_val : ((ra_q < x_q) ? ra_q : x_q);

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		rd_data_q <= par_mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_set_q <= '0;
			rd_set_q  <= 1'b0;
		end else begin
			rd_set_q <= par_set_q[rd_addr];
			if (state_q == ST_CLR) begin
				par_set_q <= '0;
			end else if (par_we) begin
				par_set_q[par_wa] <= 1'b1;
			end
		end
	end

	// in-tree flags: cleared as each edge is picked, set on a link
	assign flag_we = ((state_q == ST_PICK) && (step_q != cnt_q)) ||
			((state_q == ST_LINK) && (ra_q != x_q));
	assign flag_wa = (state_q == ST_PICK) ? head_rec.key[EW-1:0] : cur_e_q;
	assign flag_wd = (state_q == ST_LINK);

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_q[flag_wa] <= flag_wd;
		end
	end

	// ---- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			cnt_q    <= '0;
			step_q   <= '0;
			x_q      <= '0;
			ra_q     <= '0;
			side_q   <= 1'b0;
			cur_e_q  <= '0;
			cur_vb_q <= '0;
			ovld_q   <= 1'b0;
			oidx_q   <= '0;
			otree_q  <= 1'b0;
			olast_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (vld_s1) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (last_s1) begin
						state_q <= ST_FLUSH;
						step_q  <= '0;
					end
				end
				ST_FLUSH: begin
					step_q <= step_q + 1'b1;
					if (step_q == CW'(NE - 1)) begin
						state_q <= ST_PICK;
						step_q  <= '0;
					end
				end
				ST_PICK: begin
					if (step_q == cnt_q) begin
						state_q <= ST_EMIT;
						step_q  <= '0;
					end else begin
						step_q   <= step_q + 1'b1;
						cur_e_q  <= head_rec.key[EW-1:0];
						cur_vb_q <= head_rec.vb;
						x_q      <= PW'(head_rec.va);
						side_q   <= 1'b0;
						if (va_ok && vb_ok && head_rec.va != head_rec.vb) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (rd_val == x_q) begin
						if (!side_q) begin
							ra_q    <= x_q;
							x_q     <= PW'(cur_vb_q);
							side_q  <= 1'b1;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_LINK;
						end
					end else begin
						state_q <= ST_HALF;
					end
				end
				ST_HALF: begin
					// path halving: x takes its grandparent
					x_q     <= rd_val;
					state_q <= ST_CHK;
				end
				ST_LINK: begin
					state_q <= ST_PICK;
				end
				ST_EMIT: begin
					if (!ovld_q || out_ready) begin
						if (step_q == cnt_q) begin
							ovld_q  <= 1'b0;
							state_q <= ST_CLR;
						end else begin
							ovld_q  <= 1'b1;
							oidx_q  <= 6'(step_q);
							otree_q <= flag_q[step_q[EW-1:0]];
							olast_q <= (step_q + 1'b1) == cnt_q;
							step_q  <= step_q + 1'b1;
						end
					end
				end
				ST_CLR: begin
					cnt_q   <= '0;
					state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid   = ovld_q;
	assign edge_index  = oidx_q;
	assign in_tree     = otree_q;
	assign last_result = olast_q;

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !in_ready) else $error("input taken while busy");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NE)) else $error("edge count overflow");
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovld_q) |-> (state_q == ST_EMIT)) else $error("result outside emit");

endmodule

// ===== rtl/core/rst_sort_cell.sv =====
// ----------------------------------------------------------------------------
// rst_sort_cell: one cell of the insertion sort chain
// Keeps the smaller record, hands the larger one on through a register;
// on drain every cell takes the held record of the cell behind it.
// ----------------------------------------------------------------------------
module rst_sort_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                ins,
	input  logic                shift,
	input  logic                in_vld,
	input  rst_pkg::edge_rec_t  in_rec,
	input  logic                nxt_vld,
	input  rst_pkg::edge_rec_t  nxt_rec,
	output logic                pass_vld,
	output rst_pkg::edge_rec_t  pass_rec,
	output logic                held_vld,
	output rst_pkg::edge_rec_t  held_rec
);
	logic               vld_q, pvld_q;
	rst_pkg::edge_rec_t rec_q, prec_q;
	logic               keep_new;

	assign keep_new = in_vld && (!vld_q || (in_rec.key < rec_q.key));

	// valid bits of the held record and of the record handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			pvld_q <= 1'b0;
		end else if (clear) begin
			vld_q  <= 1'b0;
			pvld_q <= 1'b0;
		end else if (shift) begin
			vld_q  <= nxt_vld;
			pvld_q <= 1'b0;
		end else if (ins) begin
			if (keep_new) begin
				vld_q  <= 1'b1;
				pvld_q <= vld_q;
			end else begin
				pvld_q <= in_vld;
			end
		end
	end

	// insert: keep the smaller, pass the larger; shift: move toward the head
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= nxt_rec;
		end else if (ins) begin
			if (keep_new) begin
				rec_q  <= in_rec;
				prec_q <= rec_q;
			end else begin
				prec_q <= in_rec;
			end
		end
	end

	assign pass_vld = pvld_q;
	assign pass_rec = prec_q;
	assign held_vld = vld_q;
	assign held_rec = rec_q;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: spanning tree flag check for rectilinear_spanning_tree
// Loads edge lists through the input channel, predicts the Kruskal in-tree
// flag of every edge and compares each result beat in input order. Both
// sides idle at random; one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [5:0]  va;
		logic [5:0]  vb;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] bx;
		logic [15:0] by;
		logic        last;
	} edge_beat_t;

	typedef struct {
		logic [5:0] idx;
		logic       flag;
		logic       fin;
	} flag_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [5:0] vertex_a = '0;
	logic [5:0] vertex_b = '0;
	logic [15:0] endpoint_a_x = '0;
	logic [15:0] endpoint_a_y = '0;
	logic [15:0] endpoint_b_x = '0;
	logic [15:0] endpoint_b_y = '0;
	logic last_edge = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [5:0] edge_index;
	logic in_tree;
	logic last_result;

	rectilinear_spanning_tree dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: the list being loaded
	logic [5:0]  list_va [rst_pkg::MAX_EDGES];
	logic [5:0]  list_vb [rst_pkg::MAX_EDGES];
	logic [16:0] list_man [rst_pkg::MAX_EDGES];
	logic [32:0] list_sq [rst_pkg::MAX_EDGES];
	int list_len = 0;
	flag_beat_t expected_flags[$];
	int errors = 0;
	int hold_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	longint cycles = 0;

	task automatic report(input string what, input int got, input int want);
		$display("tb: mismatch %s got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic bit sorts_first(input int p, input int q);
		if (list_man[p] != list_man[q]) return list_man[p] < list_man[q];
		if (list_sq[p] != list_sq[q]) return list_sq[p] < list_sq[q];
		return p < q;
	endfunction

	// Kruskal over the held list, flags queued in input order
	task automatic build_tree();
		int order[rst_pkg::MAX_EDGES];
		logic [5:0] parent[rst_pkg::MAX_VERTICES];
		bit flag[rst_pkg::MAX_EDGES];
		int j, e, ra, rb;
		flag_beat_t fb;
		for (int i = 0; i < list_len; i++) begin
			j = i;
			while (j > 0 && sorts_first(i, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int v = 0; v < rst_pkg::MAX_VERTICES; v++) parent[v] = 6'(v);
		for (int i = 0; i < list_len; i++) begin
			e = order[i];
			flag[e] = 0;
			ra = list_va[e];
			while (parent[ra] != ra) begin
				parent[ra] = parent[parent[ra]];
				ra = parent[ra];
			end
			rb = list_vb[e];
			while (parent[rb] != rb) begin
				parent[rb] = parent[parent[rb]];
				rb = parent[rb];
			end
			if (ra != rb) begin
				flag[e] = 1;
				if (ra < rb) parent[rb] = 6'(ra);
				else parent[ra] = 6'(rb);
			end
		end
		for (int i = 0; i < list_len; i++) begin
			fb.idx = 6'(i);
			fb.flag = flag[i];
			fb.fin = (i + 1 == list_len);
			expected_flags = {expected_flags, fb};
		end
		list_len = 0;
	endtask

	task automatic take_edge(input edge_beat_t b);
		logic [16:0] dx, dy;
		if (list_len < rst_pkg::MAX_EDGES) begin
			dx = (b.ax >= b.bx) ? 17'(b.ax - b.bx) : 17'(b.bx - b.ax);
			dy = (b.ay >= b.by) ? 17'(b.ay - b.by) : 17'(b.by - b.ay);
			list_va[list_len] = b.va;
			list_vb[list_len] = b.vb;
			list_man[list_len] = dx + dy;
			list_sq[list_len] = 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
			list_len++;
		end
		if (b.last) build_tree();
	endtask

	function automatic int gap_len();
		int r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// drive one beat at a rising edge and hold it until accepted
	task automatic send_edge(input edge_beat_t b);
		int g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_a <= b.va;
		vertex_b <= b.vb;
		endpoint_a_x <= b.ax;
		endpoint_a_y <= b.ay;
		endpoint_b_x <= b.bx;
		endpoint_b_y <= b.by;
		last_edge <= b.last;
		do @(posedge clk); while (!in_ready);
		take_edge(b);
	endtask

	function automatic edge_beat_t rand_edge(input bit last, input int nverts);
		edge_beat_t b;
		int m = $urandom_range(0, 3);
		b.va = 6'($urandom_range(0, nverts - 1));
		b.vb = ($urandom_range(0, 15) == 0) ? b.va : 6'($urandom_range(0, nverts - 1));
		// mostly small coordinates so ties in length show up
		b.ax = (m == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
		b.ay = (m == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
		b.bx = (m == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
		b.by = (m == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
		b.last = last;
		return b;
	endfunction

	// directed table: extremes, self loop, ties, single edge
	edge_beat_t directed [10] = '{
		'{6'd0, 6'd63, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 1'b0},
		'{6'd63, 6'd0, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 1'b0},
		'{6'd5, 6'd5, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0},
		'{6'd1, 6'd2, 16'h0000, 16'h0000, 16'h0002, 16'h0000, 1'b0},
		'{6'd2, 6'd3, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 1'b0},
		'{6'd1, 6'd3, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 1'b1},
		'{6'd7, 6'd9, 16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 1'b1},
		'{6'd4, 6'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1},
		'{6'd42, 6'd21, 16'h8000, 16'h0001, 16'h7fff, 16'hfffe, 1'b0},
		'{6'd21, 6'd42, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}
	};

	// result side: compare each accepted beat, cycle limit
	always @(posedge clk) begin
		flag_beat_t w;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			if (expected_flags.size() == 0) begin
				report("unexpected beat index", edge_index, -1);
			end else begin
				w = expected_flags.pop_front();
				if (edge_index !== w.idx) report("edge_index", edge_index, w.idx);
				if (in_tree !== w.flag) report("in_tree", in_tree, w.flag);
				if (last_result !== w.fin) report("last_result", last_result, w.fin);
			end
		end
		if (cycles > 2000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, a few longer ones, one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cycles <= 400;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 199) == 0) begin
			hold_cycles <= $urandom_range(10, 60);
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 70);
		end
	end

	initial begin
		int n, k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_edge(directed[i]);
		// full store: more edges than MAX_EDGES holds; those beyond it are dropped
		for (int i = 0; i < 66; i++) send_edge(rand_edge(i == 65, 64));
		in_valid <= 1'b0;
		// drain pause
		wait (expected_flags.size() == 0);
		// long receiver hold-off while the sender keeps loading
		hold_req <= 1'b1;
		for (int i = 0; i < 12; i++) send_edge(rand_edge(i == 11, 8));
		k = 0;
		while (k < 90) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 12);
			for (int i = 0; i < n; i++) send_edge(rand_edge(i == n - 1, $urandom_range(2, 64)));
			k += n;
		end
		in_valid <= 1'b0;
		wait (expected_flags.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
